### src/maze_path_recorder_reducer_macros.svh
// Assertion macros shared by the maze path recorder checker.
`ifndef MAZE_PATH_RECORDER_REDUCER_MACROS_SVH
`define MAZE_PATH_RECORDER_REDUCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define MPR_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define MPR_ASSERT_NXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);

`endif

### src/mpr_pkg.sv
// Shared codes, handshake structs and turn tables for the maze path recorder.
`default_nettype none
package mpr_pkg;

	// operations
	localparam logic [2:0] OP_DECIDE = 3'd0;
	localparam logic [2:0] OP_DEAD   = 3'd1;
	localparam logic [2:0] OP_SOLVE  = 3'd2;
	localparam logic [2:0] OP_REPLAY = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	// turns
	localparam logic [2:0] T_STRAIGHT = 3'd0;
	localparam logic [2:0] T_LEFT90   = 3'd1;
	localparam logic [2:0] T_RIGHT90  = 3'd2;
	localparam logic [2:0] T_LEFT180  = 3'd3;
	localparam logic [2:0] T_RIGHT180 = 3'd4;
	localparam logic [2:0] T_FINISHED = 3'd5;
	localparam logic [2:0] T_STOP     = 3'd6;

	// line kinds
	localparam logic [2:0] K_NONE     = 3'd0;
	localparam logic [2:0] K_LEFT     = 3'd1;
	localparam logic [2:0] K_RIGHT    = 3'd2;
	localparam logic [2:0] K_FULL     = 3'd3;
	localparam logic [2:0] K_STRAIGHT = 3'd4;

	// datapath commands
	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] CMD_NOP        = 4'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD       = 4'd1;
	localparam logic [CMD_W-1:0] CMD_EXEC       = 4'd2;
	localparam logic [CMD_W-1:0] CMD_RP_READ    = 4'd3;
	localparam logic [CMD_W-1:0] CMD_RP_DONE    = 4'd4;
	localparam logic [CMD_W-1:0] CMD_RD_INIT    = 4'd5;
	localparam logic [CMD_W-1:0] CMD_RD_READ    = 4'd6;
	localparam logic [CMD_W-1:0] CMD_RD_PUSH    = 4'd7;
	localparam logic [CMD_W-1:0] CMD_RD_FOLD    = 4'd8;
	localparam logic [CMD_W-1:0] CMD_RD_RL1     = 4'd9;
	localparam logic [CMD_W-1:0] CMD_RD_RL2     = 4'd10;
	localparam logic [CMD_W-1:0] CMD_RD_END     = 4'd11;
	localparam logic [CMD_W-1:0] CMD_RV_RA      = 4'd12;
	localparam logic [CMD_W-1:0] CMD_RV_RB      = 4'd13;
	localparam logic [CMD_W-1:0] CMD_RV_WA      = 4'd14;
	localparam logic [CMD_W-1:0] CMD_RV_WB      = 4'd15;

	typedef struct packed {
		logic [CMD_W-1:0] code;
		logic             solve_done;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       fold_ok;
		logic       rd_more;
		logic       rv_more;
		logic       out_full;
	} dp_sts_t;

	// wall-follower turn choice
	function automatic logic [2:0] choose_turn(input logic [2:0] p, input logic [2:0] c,
		input logic left_rule);
		logic [2:0] t;
		t = T_STOP;
		if (p == K_NONE && c == K_NONE) t = T_RIGHT180;
		else if (p == K_LEFT && c == K_NONE) t = T_LEFT90;
		else if (p == K_RIGHT && c == K_NONE) t = T_RIGHT90;
		else if (p == K_FULL && (c == K_NONE || c == K_STRAIGHT))
			t = left_rule ? T_LEFT90 : T_RIGHT90;
		else if (p == K_LEFT && c == K_STRAIGHT) t = left_rule ? T_LEFT90 : T_STRAIGHT;
		else if (p == K_RIGHT && c == K_STRAIGHT) t = left_rule ? T_STRAIGHT : T_RIGHT90;
		else if (p == K_FULL && c == K_FULL) t = T_FINISHED;
		return t;
	endfunction

	// folded turn for before / U-turn / after; both neighbors already checked valid
	function automatic logic [2:0] fold_triple(input logic [2:0] a, input logic [2:0] b);
		logic [2:0] r;
		r = T_LEFT180;
		if (a == T_STRAIGHT && b == T_LEFT90) r = T_RIGHT90;
		else if (a == T_LEFT90 && b == T_LEFT90) r = T_STRAIGHT;
		else if (a == T_LEFT90 && b == T_RIGHT90) r = T_LEFT180;
		else if (a == T_RIGHT90 && b == T_LEFT90) r = T_LEFT180;
		else if (a == T_LEFT90 && b == T_STRAIGHT) r = T_RIGHT90;
		else if (a == T_RIGHT90 && b == T_STRAIGHT) r = T_LEFT90;
		else if (a == T_RIGHT90 && b == T_RIGHT90) r = T_STRAIGHT;
		else if (a == T_STRAIGHT && b == T_RIGHT90) r = T_LEFT90;
		return r;
	endfunction

	// swap left90 and right90 for the way back
	function automatic logic [2:0] mirror(input logic [2:0] t);
		logic [2:0] m;
		m = t;
		if (t == T_LEFT90) m = T_RIGHT90;
		else if (t == T_RIGHT90) m = T_LEFT90;
		return m;
	endfunction

endpackage
`default_nettype wire

### src/mpr_ctrl.sv
// Controller state machine sequencing requests, reduction and reversal.
`default_nettype none
module mpr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire mpr_pkg::dp_sts_t sts,
	output mpr_pkg::dp_cmd_t     cmd
);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DISP     = 5'd1;
	localparam logic [4:0] S_EXEC     = 5'd2;
	localparam logic [4:0] S_RP_RD    = 5'd3;
	localparam logic [4:0] S_RP_DONE  = 5'd4;
	localparam logic [4:0] S_RD_INIT  = 5'd5;
	localparam logic [4:0] S_RD_CHECK = 5'd6;
	localparam logic [4:0] S_RD_READ  = 5'd7;
	localparam logic [4:0] S_RD_PUSH  = 5'd8;
	localparam logic [4:0] S_RD_FOLD  = 5'd9;
	localparam logic [4:0] S_RD_RL1   = 5'd10;
	localparam logic [4:0] S_RD_RL2   = 5'd11;
	localparam logic [4:0] S_RD_END   = 5'd12;
	localparam logic [4:0] S_RV_CHECK = 5'd13;
	localparam logic [4:0] S_RV_RA    = 5'd14;
	localparam logic [4:0] S_RV_RB    = 5'd15;
	localparam logic [4:0] S_RV_WA    = 5'd16;
	localparam logic [4:0] S_RV_WB    = 5'd17;
	localparam logic [4:0] S_SV_DONE  = 5'd18;

	logic [4:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.code = mpr_pkg::CMD_NOP;
		cmd.solve_done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = mpr_pkg::CMD_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.op == mpr_pkg::OP_SOLVE) state_d = S_RD_INIT;
				else if (sts.op == mpr_pkg::OP_REPLAY) state_d = S_RP_RD;
				else state_d = S_EXEC;
			end
			S_EXEC: begin
				if (!sts.out_full) begin
					cmd.code = mpr_pkg::CMD_EXEC;
					state_d = S_IDLE;
				end
			end
			S_RP_RD: begin
				cmd.code = mpr_pkg::CMD_RP_READ;
				state_d = S_RP_DONE;
			end
			S_RP_DONE: begin
				// output busy: keep reading the same entry so the data stays put
				if (!sts.out_full) begin
					cmd.code = mpr_pkg::CMD_RP_DONE;
					state_d = S_IDLE;
				end else begin
					cmd.code = mpr_pkg::CMD_RP_READ;
				end
			end
			S_RD_INIT: begin
				cmd.code = mpr_pkg::CMD_RD_INIT;
				state_d = S_RD_CHECK;
			end
			S_RD_CHECK: begin
				if (sts.fold_ok) state_d = S_RD_FOLD;
				else if (sts.rd_more) state_d = S_RD_READ;
				else state_d = S_RD_END;
			end
			S_RD_READ: begin
				cmd.code = mpr_pkg::CMD_RD_READ;
				state_d = S_RD_PUSH;
			end
			S_RD_PUSH: begin
				cmd.code = mpr_pkg::CMD_RD_PUSH;
				state_d = S_RD_CHECK;
			end
			S_RD_FOLD: begin
				cmd.code = mpr_pkg::CMD_RD_FOLD;
				state_d = S_RD_RL1;
			end
			S_RD_RL1: begin
				cmd.code = mpr_pkg::CMD_RD_RL1;
				state_d = S_RD_RL2;
			end
			S_RD_RL2: begin
				cmd.code = mpr_pkg::CMD_RD_RL2;
				state_d = S_RD_CHECK;
			end
			S_RD_END: begin
				cmd.code = mpr_pkg::CMD_RD_END;
				state_d = S_RV_CHECK;
			end
			S_RV_CHECK: begin
				state_d = sts.rv_more ? S_RV_RA : S_SV_DONE;
			end
			S_RV_RA: begin
				cmd.code = mpr_pkg::CMD_RV_RA;
				state_d = S_RV_RB;
			end
			S_RV_RB: begin
				cmd.code = mpr_pkg::CMD_RV_RB;
				state_d = S_RV_WA;
			end
			S_RV_WA: begin
				cmd.code = mpr_pkg::CMD_RV_WA;
				state_d = S_RV_WB;
			end
			S_RV_WB: begin
				cmd.code = mpr_pkg::CMD_RV_WB;
				state_d = S_RV_CHECK;
			end
			S_SV_DONE: begin
				if (!sts.out_full) begin
					cmd.solve_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

### src/mpr_dp.sv
// Datapath: path store, counters, reduction stack registers and result register.
`default_nettype none
module mpr_dp #(
	parameter int PATH_DEPTH = 128
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mpr_pkg::dp_cmd_t cmd,
	output mpr_pkg::dp_sts_t      sts,
	input  wire logic [2:0]       operation,
	input  wire logic [2:0]       prev_kind,
	input  wire logic [2:0]       curr_kind,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [2:0]            turn,
	output logic [7:0]            path_count,
	output logic                  solved,
	output logic                  overflow
);

	localparam int AW = $clog2(PATH_DEPTH);
	localparam int CW = $clog2(PATH_DEPTH + 1);

	logic [2:0] mem [PATH_DEPTH];
	logic [2:0] rdata_q;

	logic [2:0] op_q, pk_q, ck_q;
	logic hand_q, solved_q, out_valid_q;
	logic [CW-1:0] count_q, ridx_q, wp_q, rp_q, ri_q;
	logic [2:0] ta_q, tb_q, tc_q, da_q;
	logic [2:0] turn_q;
	logic [CW-1:0] cnt_out_q;
	logic ovf_q;

	logic full, app, we, out_load;
	logic [2:0] dec_turn, exec_turn, fold_r, wdata, turn_n;
	logic [CW-1:0] rv_j, cnt_n, waddr_w, raddr_w;
	logic sol_n, ovf_n;
	logic [CW+7:0] cnt_ext;

	// decode of the captured request
	always_comb begin
		full = (count_q == CW'(PATH_DEPTH));
		dec_turn = mpr_pkg::choose_turn(pk_q, ck_q, hand_q);
		case (op_q)
			mpr_pkg::OP_DECIDE: exec_turn = dec_turn;
			mpr_pkg::OP_DEAD:   exec_turn = mpr_pkg::T_LEFT180;
			mpr_pkg::OP_CLEAR:  exec_turn = mpr_pkg::T_STRAIGHT;
			default:            exec_turn = mpr_pkg::T_STOP;
		endcase
		app = (op_q == mpr_pkg::OP_DECIDE && dec_turn <= mpr_pkg::T_RIGHT180)
			|| op_q == mpr_pkg::OP_DEAD;
		fold_r = mpr_pkg::fold_triple(tc_q, ta_q);
		rv_j = count_q - CW'(1) - ri_q;
	end

	// store port selection
	always_comb begin
		we = 1'b0;
		waddr_w = '0;
		wdata = '0;
		raddr_w = '0;
		case (cmd.code)
			mpr_pkg::CMD_EXEC: begin
				we = app && !full;
				waddr_w = count_q;
				wdata = exec_turn;
			end
			mpr_pkg::CMD_RP_READ: raddr_w = ridx_q;
			mpr_pkg::CMD_RD_READ: raddr_w = rp_q;
			mpr_pkg::CMD_RD_PUSH: begin
				we = 1'b1;
				waddr_w = wp_q;
				wdata = rdata_q;
			end
			mpr_pkg::CMD_RD_FOLD: begin
				we = 1'b1;
				waddr_w = wp_q - CW'(3);
				wdata = fold_r;
				raddr_w = wp_q - CW'(4);
			end
			mpr_pkg::CMD_RD_RL1: raddr_w = wp_q - CW'(3);
			mpr_pkg::CMD_RV_RA:  raddr_w = ri_q;
			mpr_pkg::CMD_RV_RB:  raddr_w = rv_j;
			mpr_pkg::CMD_RV_WA: begin
				we = 1'b1;
				waddr_w = ri_q;
				wdata = mpr_pkg::mirror(rdata_q);
			end
			mpr_pkg::CMD_RV_WB: begin
				we = 1'b1;
				waddr_w = rv_j;
				wdata = mpr_pkg::mirror(da_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// path store, registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr_w[AW-1:0]] <= wdata;
		rdata_q <= mem[raddr_w[AW-1:0]];
	end

	// result of the finishing step
	always_comb begin
		cnt_n = count_q;
		sol_n = solved_q;
		ovf_n = 1'b0;
		turn_n = exec_turn;
		out_load = 1'b0;
		if (cmd.solve_done) begin
			out_load = 1'b1;
			sol_n = 1'b1;
			turn_n = mpr_pkg::T_STRAIGHT;
		end else if (cmd.code == mpr_pkg::CMD_EXEC) begin
			out_load = 1'b1;
			if (app) begin
				if (full) ovf_n = 1'b1;
				else cnt_n = count_q + CW'(1);
			end
			if (op_q == mpr_pkg::OP_CLEAR) begin
				cnt_n = '0;
				sol_n = 1'b0;
			end
		end else if (cmd.code == mpr_pkg::CMD_RP_DONE) begin
			out_load = 1'b1;
			turn_n = (ridx_q < count_q) ? rdata_q : mpr_pkg::T_STOP;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_q <= 1'b1;
			count_q <= '0;
			solved_q <= 1'b0;
			ridx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) hand_q <= cfg_wdata;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (out_load) begin
				count_q <= cnt_n;
				solved_q <= sol_n;
			end
			if (cmd.solve_done) ridx_q <= '0;
			else if (cmd.code == mpr_pkg::CMD_EXEC && op_q == mpr_pkg::OP_CLEAR) ridx_q <= '0;
			else if (cmd.code == mpr_pkg::CMD_RP_DONE && ridx_q < count_q)
				ridx_q <= ridx_q + CW'(1);
			if (cmd.code == mpr_pkg::CMD_RD_END) count_q <= wp_q;
		end
	end

	// payload and work registers
	always_ff @(posedge clk) begin
		case (cmd.code)
			mpr_pkg::CMD_LOAD: begin
				op_q <= operation;
				pk_q <= prev_kind;
				ck_q <= curr_kind;
			end
			mpr_pkg::CMD_RD_INIT: begin
				wp_q <= '0;
				rp_q <= '0;
			end
			mpr_pkg::CMD_RD_PUSH: begin
				wp_q <= wp_q + CW'(1);
				rp_q <= rp_q + CW'(1);
				tc_q <= tb_q;
				tb_q <= ta_q;
				ta_q <= rdata_q;
			end
			mpr_pkg::CMD_RD_FOLD: begin
				wp_q <= wp_q - CW'(2);
				ta_q <= fold_r;
			end
			mpr_pkg::CMD_RD_RL1: tb_q <= rdata_q;
			mpr_pkg::CMD_RD_RL2: tc_q <= rdata_q;
			mpr_pkg::CMD_RD_END: ri_q <= '0;
			mpr_pkg::CMD_RV_RB:  da_q <= rdata_q;
			mpr_pkg::CMD_RV_WB:  ri_q <= ri_q + CW'(1);
			default: begin
				op_q <= op_q;
			end
		endcase
		if (out_load) begin
			turn_q <= turn_n;
			cnt_out_q <= cnt_n;
			ovf_q <= ovf_n;
		end
	end

	// status to the controller
	always_comb begin
		sts.op = op_q;
		sts.fold_ok = (wp_q >= CW'(3)) && (tb_q == mpr_pkg::T_LEFT180)
			&& (ta_q <= mpr_pkg::T_RIGHT90) && (tc_q <= mpr_pkg::T_RIGHT90);
		sts.rd_more = (rp_q < count_q);
		sts.rv_more = ({ri_q, 1'b1} <= {1'b0, count_q});
		sts.out_full = out_valid_q && !out_ready;
	end

	assign cnt_ext = {8'd0, cnt_out_q};
	assign out_valid = out_valid_q;
	assign turn = turn_q;
	assign path_count = cnt_ext[7:0];
	assign solved = solved_q;
	assign overflow = ovf_q;

endmodule
`default_nettype wire

### src/maze_path_recorder_reducer.sv
// Top level of the maze path recorder: controller plus datapath.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+--------------------
//  request | operation, prev_kind, curr_kind           | in_valid / in_ready
//  result  | turn, path_count, solved, overflow        | out_valid / out_ready
//  config  | cfg_wdata (hand_rule)                     | cfg_we, no wait
//
// Decide, dead end, clear and unknown codes go through dispatch and execute;
// replay adds a store read before its result. Solve runs on the single store
// port: a reduction scan reads and pushes each stored turn and folds U-turns;
// the reversal swaps pairs (the middle turn of an odd path counts as a pair).
// One request is in work at a time; a pending result stalls only the final step.
// arst_n clears count, replay index, solved, valid, hand rule, FSM; not store.
`default_nettype none
module maze_path_recorder_reducer #(
	parameter int PATH_DEPTH = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] operation,
	input  wire logic [2:0] prev_kind,
	input  wire logic [2:0] curr_kind,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      turn,
	output logic [7:0]      path_count,
	output logic            solved,
	output logic            overflow,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata
);

	mpr_pkg::dp_cmd_t cmd;
	mpr_pkg::dp_sts_t sts;

	mpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mpr_dp #(.PATH_DEPTH(PATH_DEPTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.prev_kind  (prev_kind),
		.curr_kind  (curr_kind),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.turn       (turn),
		.path_count (path_count),
		.solved     (solved),
		.overflow   (overflow)
	);

endmodule
`default_nettype wire

### src/mpr_chk.sv
// Port-level checker for the maze path recorder, bound to the top level.
`default_nettype none
`include "maze_path_recorder_reducer_macros.svh"
module mpr_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] turn,
	input wire logic       overflow
);

	// a result is held until taken
	`MPR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
	// result turn code is always one of the defined ones
	`MPR_ASSERT_NOW(a_turn_code, out_valid, turn <= mpr_pkg::T_STOP, "undefined turn code")
	// only appended turns can overflow
	`MPR_ASSERT_NOW(a_ovf_turn, out_valid && overflow, turn <= mpr_pkg::T_RIGHT180, "overflow on non-append")
	// a request accepted is not accepted again in the next cycle
	`MPR_ASSERT_NXT(a_one_req, in_valid && in_ready, !in_ready, "back-to-back accept")

endmodule

bind maze_path_recorder_reducer mpr_chk u_mpr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.turn      (turn),
	.overflow  (overflow)
);
`default_nettype wire
